// File: hdl/bgdr_pkg.sv
package bgdr_pkg;

	localparam int MaxSamples  = 1024;
	localparam int MaxFeatures = 16;
	localparam int SampW       = $clog2(MaxSamples);
	localparam int FeatW       = $clog2(MaxFeatures);
	localparam int CntW        = SampW + 1;
	localparam int FAddrW      = SampW + FeatW;

	localparam logic [1:0] CfgLearningRate   = 2'd0;
	localparam logic [1:0] CfgIterationCount = 2'd1;
	localparam logic [1:0] CfgFeaturesInUse  = 2'd2;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (v > 65'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -65'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			return s[63:0];
	endfunction

endpackage

// File: hdl/batch_gradient_descent_regression.sv
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/ready  | feature_value target_value end_of_row end_of_set
// out     | output    | out_valid/ready | coef_index coef_value last_coef rows_dropped
// cfg     | input     | cfg_we          | cfg_index cfg_data
// Loading takes one element per cycle while in_ready is high; a row that ends short
// pads the rest of the row, one element a cycle, with in_ready low. Training clears,
// then per iteration and sample forms the prediction, the error and the gradients
// through one shared 32x32 multiplier, then per coefficient waits on a 64-step divider.
// Emit sends n beats, one per cycle while out_ready is high.
// Asynchronous reset clears control state; stores need no clearing.
// Results wait in an output register; out_ready stalls the emit sequence only.
module batch_gradient_descent_regression (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] feature_value,
	input  logic signed [31:0] target_value,
	input  logic               end_of_row,
	input  logic               end_of_set,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         coef_index,
	output logic signed [31:0] coef_value,
	output logic               last_coef,
	output logic               rows_dropped,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int SW = bgdr_pkg::SampW;
	localparam int FW = bgdr_pkg::FeatW;
	localparam int CW = bgdr_pkg::CntW;

	typedef enum logic [3:0] {
		ST_LOAD, ST_PAD, ST_INIT, ST_PRED, ST_PRED_W, ST_ERR, ST_GRAD, ST_GRAD_W,
		ST_DIV, ST_DIV_W, ST_STEP, ST_STEP_W, ST_EMIT
	} state_t;

	state_t state_q;

	logic [15:0] lr_q;
	logic [15:0] iter_cfg_q;
	logic [4:0]  nfeat_cfg_q;

	logic signed [31:0] fmem [bgdr_pkg::MaxSamples * bgdr_pkg::MaxFeatures];
	logic signed [31:0] tmem [bgdr_pkg::MaxSamples];
	logic signed [31:0] coef_q [16];
	logic signed [63:0] grad_q [16];

	logic [CW-1:0] scount_q;
	logic [FW:0]   epos_q;
	logic          ovf_q;

	logic [15:0]   it_q;
	logic [SW-1:0] j_q;
	logic [FW-1:0] k_q;
	logic [4:0]    n_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] err_q;
	logic signed [31:0] frd_q;
	logic signed [31:0] trd_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] ma, mb;
	logic               rd_pend_q;

	logic               div_start;
	logic               div_done;
	logic signed [63:0] div_quo;

	logic [4:0] n_eff;
	assign n_eff = (nfeat_cfg_q == 5'd0) ? 5'd1 :
		(nfeat_cfg_q > 5'(bgdr_pkg::MaxFeatures)) ? 5'(bgdr_pkg::MaxFeatures) : nfeat_cfg_q;

	logic [FW-1:0] k_last;
	assign k_last = FW'(n_q - 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q        <= 16'd655;
			iter_cfg_q  <= 16'd100;
			nfeat_cfg_q <= 5'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bgdr_pkg::CfgLearningRate:   lr_q        <= cfg_data;
				bgdr_pkg::CfgIterationCount: iter_cfg_q  <= cfg_data;
				bgdr_pkg::CfgFeaturesInUse:  nfeat_cfg_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	logic          fwe;
	logic [bgdr_pkg::FAddrW-1:0] fwa;
	logic signed [31:0] fwd;
	logic [bgdr_pkg::FAddrW-1:0] fra;
	logic          room;
	logic          in_acc;
	logic          row_end;

	assign room    = scount_q < CW'(bgdr_pkg::MaxSamples);
	assign in_ready = (state_q == ST_LOAD);
	assign in_acc  = in_valid && in_ready;
	assign row_end = end_of_row || end_of_set;

	always_comb begin
		fwe = 1'b0;
		fwa = {scount_q[SW-1:0], epos_q[FW-1:0]};
		fwd = feature_value;
		if (state_q == ST_LOAD) begin
			fwe = in_acc && room && !epos_q[FW];
		end else if (state_q == ST_PAD) begin
			fwe = 1'b1;
			fwd = '0;
		end
	end

	assign fra = {j_q, k_q};

	always_ff @(posedge clk) begin
		if (fwe)
			fmem[fwa] <= fwd;
		if (in_acc && row_end && room)
			tmem[scount_q[SW-1:0]] <= target_value;
		frd_q <= fmem[fra];
		trd_q <= tmem[j_q];
	end

	always_comb begin
		ma = err_q;
		mb = frd_q;
		if (state_q == ST_PRED || state_q == ST_PRED_W)
			ma = coef_q[k_q];
		else if (state_q == ST_STEP || state_q == ST_STEP_W) begin
			ma = $signed({16'd0, lr_q});
			mb = err_q;
		end
	end

	logic signed [63:0] twice;
	logic signed [31:0] g16;
	logic signed [63:0] step;
	assign twice = (prod_q > 64'sh3fffffffffffffff) ? 64'sh7fffffffffffffff :
		(prod_q < -64'sh4000000000000000) ? {1'b1, 63'd0} : (prod_q <<< 1);
	assign g16  = bgdr_pkg::sat32(65'(div_quo >>> 16));
	assign step = prod_q >>> 16;

	assign div_start = (state_q == ST_DIV);

	bgdr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (grad_q[k_q]),
		.divisor  (scount_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (!rd_pend_q)
			prod_q <= ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			scount_q  <= '0;
			epos_q    <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
			rd_pend_q <= 1'b0;
			for (int i = 0; i < 16; i++)
				coef_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (row_end && room &&
							epos_q < (FW+1)'(bgdr_pkg::MaxFeatures - 1)) begin
							epos_q  <= epos_q + 1'b1;
							state_q <= ST_PAD;
						end else if (row_end) begin
							if (room)
								scount_q <= scount_q + 1'b1;
							else
								ovf_q <= 1'b1;
							epos_q <= '0;
							if (end_of_set)
								state_q <= ST_INIT;
						end else if (!epos_q[FW])
							epos_q <= epos_q + 1'b1;
						n_q <= n_eff;
						rd_pend_q <= end_of_set;
					end
				end
				ST_PAD: begin
					if (epos_q == (FW+1)'(bgdr_pkg::MaxFeatures - 1)) begin
						scount_q <= scount_q + 1'b1;
						epos_q   <= '0;
						state_q  <= rd_pend_q ? ST_INIT : ST_LOAD;
					end else
						epos_q <= epos_q + 1'b1;
				end
				ST_INIT: begin
					for (int i = 0; i < 16; i++)
						coef_q[i] <= '0;
					it_q <= 16'd0;
					j_q <= '0;
					k_q <= '0;
					acc_q <= '0;
					rd_pend_q <= 1'b0;
					for (int i = 0; i < 16; i++)
						grad_q[i] <= '0;
					if (iter_cfg_q == 16'd0)
						state_q <= ST_EMIT;
					else if (scount_q == '0)
						state_q <= ST_DIV;
					else
						state_q <= ST_PRED;
					out_valid <= (iter_cfg_q == 16'd0);
				end
				ST_PRED: begin
					// address k issued; data arrives next cycle, product the one after
					state_q <= ST_PRED_W;
				end
				ST_PRED_W: begin
					rd_pend_q <= !rd_pend_q;
					if (rd_pend_q) begin
						acc_q <= bgdr_pkg::add_sat64(acc_q, prod_q);
						if (k_q == k_last) begin
							k_q <= '0;
							state_q <= ST_ERR;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= ST_PRED;
						end
					end
				end
				ST_ERR: begin
					err_q <= bgdr_pkg::sat32(65'(bgdr_pkg::sat32(65'(acc_q >>> 16))) - 65'(trd_q));
					acc_q <= '0;
					state_q <= ST_GRAD;
				end
				ST_GRAD: state_q <= ST_GRAD_W;
				ST_GRAD_W: begin
					rd_pend_q <= !rd_pend_q;
					if (rd_pend_q) begin
						grad_q[k_q] <= bgdr_pkg::add_sat64(grad_q[k_q], twice);
						if (k_q == k_last) begin
							k_q <= '0;
							if (CW'(j_q) == scount_q - 1'b1) begin
								j_q <= '0;
								state_q <= ST_DIV;
							end else begin
								j_q <= j_q + 1'b1;
								state_q <= ST_PRED;
							end
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= ST_GRAD;
						end
					end
				end
				ST_DIV: state_q <= ST_DIV_W;
				ST_DIV_W: begin
					if (div_done || scount_q == '0) begin
						err_q <= (scount_q == '0) ? 32'sd0 : g16;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: state_q <= ST_STEP_W;
				ST_STEP_W: begin
					coef_q[k_q] <= bgdr_pkg::sat32(65'(coef_q[k_q]) - 65'(step));
					grad_q[k_q] <= '0;
					if (k_q == k_last) begin
						k_q <= '0;
						if (it_q == iter_cfg_q - 16'd1) begin
							state_q   <= ST_EMIT;
							out_valid <= 1'b1;
						end else begin
							it_q <= it_q + 16'd1;
							state_q <= (scount_q == '0) ? ST_DIV : ST_PRED;
						end
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						if (k_q == k_last) begin
							out_valid <= 1'b0;
							k_q <= '0;
							scount_q <= '0;
							ovf_q <= 1'b0;
							state_q <= ST_LOAD;
						end else
							k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign coef_index   = 4'(k_q);
	assign coef_value   = coef_q[k_q];
	assign last_coef    = (k_q == k_last);
	assign rows_dropped = ovf_q;

endmodule

// File: hdl/bgdr_div.sv
module bgdr_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [63:0]             dividend,
	input  logic [bgdr_pkg::CntW-1:0]      divisor,
	output logic                           done,
	output logic signed [63:0]             quotient
);

	logic [63:0] mag_q;
	logic [63:0] rem_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {rem_q, mag_q[63]} - {{(65 - bgdr_pkg::CntW){1'b0}}, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= !start && busy_q && (cnt_q == 7'd63);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
				neg_q  <= dividend[63];
				mag_q  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
				rem_q  <= '0;
			end else if (busy_q) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					mag_q <= {mag_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], mag_q[63]};
					mag_q <= {mag_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63)
					busy_q <= 1'b0;
			end
		end
	end

	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// File: hdl/bgdr_checker.sv
module bgdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  coef_index,
	input logic        last_coef
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken during emit");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_coef |=>
		out_valid && coef_index == $past(coef_index) + 4'd1)
		else $error("coefficient index skipped");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_coef |=> !out_valid)
		else $error("emit ran past last coefficient");

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> coef_index == 4'd0)
		else $error("emit did not start at zero");

endmodule

bind batch_gradient_descent_regression bgdr_checker u_bgdr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.coef_index (coef_index),
	.last_coef  (last_coef)
);

// File: sim/batch_gradient_descent_regression_test.sv
module batch_gradient_descent_regression_test;

	localparam int WatchLimit = 2000000;

	typedef struct {
		logic [3:0]         idx;
		logic signed [31:0] val;
		logic               last;
		logic               drop;
	} coef_t;

	typedef struct {
		bit                 is_cfg;
		logic [1:0]         reg_idx;
		logic [15:0]        reg_data;
		logic signed [31:0] fv;
		logic signed [31:0] tv;
		logic               eor;
		logic               eos;
		bit                 all_zero;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] feature_value;
	logic signed [31:0] target_value;
	logic               end_of_row;
	logic               end_of_set;
	logic               out_valid;
	logic               out_ready;
	logic [3:0]         coef_index;
	logic signed [31:0] coef_value;
	logic               last_coef;
	logic               rows_dropped;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	int    feat_mem [bgdr_pkg::MaxSamples][bgdr_pkg::MaxFeatures];
	int    tgt_mem [bgdr_pkg::MaxSamples];
	int    coefs [16];
	longint grads [16];
	int    held_rows;
	int    elem_pos;
	bit    rows_lost;
	int    rate;
	int    passes;
	int    feats_cfg;
	bit    force_zero;
	bit    gaps_on;
	int    fails;
	int    quiet_cycles;
	coef_t coef_q [$];

	batch_gradient_descent_regression i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint add_clamp(longint a, longint b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
		return s[63:0];
	endfunction

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return int'(v);
	endfunction

	task automatic fit_coefs(int n);
		longint acc, p, twice, g, step;
		int pred, err, g16;
		for (int k = 0; k < 16; k++)
			coefs[k] = 0;
		for (int it = 0; it < passes; it++) begin
			for (int k = 0; k < 16; k++)
				grads[k] = 0;
			for (int j = 0; j < held_rows; j++) begin
				acc = 0;
				for (int k = 0; k < n; k++)
					acc = add_clamp(acc, longint'(coefs[k]) * longint'(feat_mem[j][k]));
				pred = clamp32(acc >>> 16);
				err = clamp32(longint'(pred) - longint'(tgt_mem[j]));
				for (int k = 0; k < n; k++) begin
					p = longint'(err) * longint'(feat_mem[j][k]);
					if (p > 64'sh3fffffffffffffff)
						twice = 64'sh7fffffffffffffff;
					else if (p < -64'sh4000000000000000)
						twice = 64'sh8000000000000000;
					else
						twice = p * 2;
					grads[k] = add_clamp(grads[k], twice);
				end
			end
			for (int k = 0; k < n; k++) begin
				g = held_rows != 0 ? grads[k] / longint'(held_rows) : 0;
				g16 = clamp32(g >>> 16);
				step = (longint'(rate) * longint'(g16)) >>> 16;
				coefs[k] = clamp32(longint'(coefs[k]) - step);
			end
		end
	endtask

	task automatic absorb_beat(int fv, int tv, bit eor, bit eos);
		bit room;
		int n;
		coef_t c;
		room = held_rows < bgdr_pkg::MaxSamples;
		if (room && elem_pos < bgdr_pkg::MaxFeatures)
			feat_mem[held_rows][elem_pos] = fv;
		if (elem_pos < bgdr_pkg::MaxFeatures)
			elem_pos++;
		if (eor || eos) begin
			if (room) begin
				for (int p = elem_pos; p < bgdr_pkg::MaxFeatures; p++)
					feat_mem[held_rows][p] = 0;
				tgt_mem[held_rows] = tv;
				held_rows++;
			end else begin
				rows_lost = 1'b1;
			end
			elem_pos = 0;
		end
		if (!eos)
			return;
		n = feats_cfg == 0 ? 1 : (feats_cfg > 16 ? 16 : feats_cfg);
		fit_coefs(n);
		for (int k = 0; k < n; k++) begin
			c.idx = k[3:0];
			c.val = force_zero ? 32'sd0 : coefs[k];
			c.last = k + 1 == n;
			c.drop = rows_lost;
			coef_q = {coef_q, c};
		end
		held_rows = 0;
		elem_pos = 0;
		rows_lost = 1'b0;
	endtask

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fails++;
	endtask

	task automatic send_beat(logic signed [31:0] fv, logic signed [31:0] tv, logic eor,
		logic eos);
		if (gaps_on && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (gaps_on && $urandom_range(99) < 35);
		end
		in_valid <= 1'b1;
		feature_value <= fv;
		target_value <= tv;
		end_of_row <= eor;
		end_of_set <= eos;
		do @(posedge clk); while (!in_ready);
		absorb_beat(fv, tv, eor, eos);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (coef_q.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bgdr_pkg::CfgLearningRate:   rate = int'(data);
			bgdr_pkg::CfgIterationCount: passes = int'(data);
			bgdr_pkg::CfgFeaturesInUse:  feats_cfg = int'(data[4:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom;
			3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom_range(32'h7ffff) - 32'sh40000;
		endcase
	endfunction

	always @(posedge clk) begin
		coef_t e;
		if (out_valid && out_ready) begin
			if (coef_q.size() == 0) begin
				report($sformatf("unexpected coefficient %0d", coef_index));
			end else begin
				e = coef_q.pop_front();
				if (coef_index !== e.idx)
					report($sformatf("coef_index %0d, want %0d", coef_index, e.idx));
				if (coef_value !== e.val)
					report($sformatf("coef_value[%0d] %h, want %h", e.idx, coef_value, e.val));
				if (last_coef !== e.last)
					report($sformatf("last_coef[%0d] %b, want %b", e.idx, last_coef, e.last));
				if (rows_dropped !== e.drop)
					report($sformatf("rows_dropped[%0d] %b, want %b", e.idx, rows_dropped,
						e.drop));
			end
		end
		out_ready <= gaps_on ? ($urandom_range(99) >= 35) : 1'b1;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("batch_gradient_descent_regression verification failed");
			$finish;
		end
	end

	initial begin
		row_t plan [21];
		int rows, len, n_eff, rand_beats;
		bit last;
		logic eor, eos;
		plan = '{
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sd0, 32'sd0, 0, 1, 1},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh00010000, 32'sd0, 0, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh00020000, 32'sd0, 0, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh00030000, 32'sh00060000, 1, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh7fffffff, 32'sd0, 0, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh80000000, 32'sh7fffffff, 1, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh00010000, 32'sh80000000, 0, 1, 0},
			'{1, bgdr_pkg::CfgLearningRate, 16'd0, 0, 0, 0, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh12345678, 32'sh00ff0000, 1, 1, 1},
			'{1, bgdr_pkg::CfgFeaturesInUse, 16'd0, 0, 0, 0, 0, 0},
			'{1, bgdr_pkg::CfgIterationCount, 16'd4095, 0, 0, 0, 0, 0},
			'{1, bgdr_pkg::CfgLearningRate, 16'hffff, 0, 0, 0, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh00010000, 32'sh00020000, 0, 1, 0},
			'{1, bgdr_pkg::CfgIterationCount, 16'd1, 0, 0, 0, 0, 0},
			'{1, bgdr_pkg::CfgFeaturesInUse, 16'd31, 0, 0, 0, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh7fffffff, 32'sh80000000, 0, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh80000000, 32'sh7fffffff, 1, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'shffffffff, 32'sh00000001, 0, 1, 0},
			'{1, bgdr_pkg::CfgFeaturesInUse, 16'd16, 0, 0, 0, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'sh55555555, 32'shaaaaaaaa, 0, 0, 0},
			'{0, bgdr_pkg::CfgLearningRate, 0, 32'shaaaaaaaa, 32'sh55555555, 0, 1, 0}
		};
		for (int k = 0; k < bgdr_pkg::MaxSamples; k++) begin
			tgt_mem[k] = 0;
			for (int p = 0; p < bgdr_pkg::MaxFeatures; p++)
				feat_mem[k][p] = 0;
		end
		for (int k = 0; k < 16; k++)
			coefs[k] = 0;
		held_rows = 0;
		elem_pos = 0;
		rows_lost = 1'b0;
		rate = 655;
		passes = 100;
		feats_cfg = 6;
		force_zero = 1'b0;
		gaps_on = 1'b1;
		fails = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		feature_value = '0;
		target_value = '0;
		end_of_row = 1'b0;
		end_of_set = 1'b0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].reg_idx, plan[i].reg_data);
			end else begin
				force_zero = plan[i].all_zero;
				send_beat(plan[i].fv, plan[i].tv, plan[i].eor, plan[i].eos);
				force_zero = 1'b0;
			end
		end

		rand_beats = 0;
		while (rand_beats < 170) begin
			drain();
			// first random sets run with no idling on either side
			gaps_on = rand_beats >= 60;
			write_reg(bgdr_pkg::CfgLearningRate,
				$urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2000)));
			write_reg(bgdr_pkg::CfgIterationCount, 16'($urandom_range(1, 6)));
			write_reg(bgdr_pkg::CfgFeaturesInUse, $urandom_range(7) == 0 ?
				16'($urandom_range(31)) : 16'($urandom_range(1, 16)));
			n_eff = feats_cfg == 0 ? 1 : (feats_cfg > 16 ? 16 : feats_cfg);
			rows = $urandom_range(1, 6);
			for (int r = 0; r < rows; r++) begin
				len = $urandom_range(99) < 80 ? n_eff : $urandom_range(1, 18);
				for (int e = 0; e < len; e++) begin
					last = e == len - 1;
					eos = last && r == rows - 1;
					eor = last && !(eos && $urandom_range(1));
					send_beat(pick_value(), pick_value(), eor, eos);
					rand_beats++;
				end
			end
		end
		gaps_on = 1'b1;

		in_valid <= 1'b0;
		wait (coef_q.size() == 0);
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("batch_gradient_descent_regression verification clean");
		else
			$display("batch_gradient_descent_regression verification failed");
		$finish;
	end

endmodule
